FILE: rtl/sprg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprg_pkg
// Shared types and constants for the stepper pulse ramp generator.
// ----------------------------------------------------------------------------
package sprg_pkg;

	localparam int HP_W          = 16;   // half-period and register width
	localparam int STEP_W        = 16;   // step count field width
	localparam int CFG_IDX_W     = 1;
	localparam int COUNT_W_DEF   = 16;
	localparam int RAMP_DIV      = 5;
	localparam int SNAP_MARGIN   = 5;

	localparam logic [HP_W-1:0] MIN_HP_RESET = 16'd500;
	localparam logic [HP_W-1:0] MAX_HP_RESET = 16'd2000;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_HP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HP = 1'b1;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_MOVE = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_ACCEL  = 4'b0010,
		PH_CRUISE = 4'b0100,
		PH_DECEL  = 4'b1000
	} phase_t;

endpackage

`default_nettype wire

FILE: rtl/sprg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprg_if
// Handshake channels of the ramp generator: command, result and config write.
// ----------------------------------------------------------------------------
interface sprg_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [sprg_pkg::STEP_W-1:0]   step_count;

	modport source (output valid, output op, output step_count, input ready);
	modport sink   (input valid, input op, input step_count, output ready);
endinterface

interface sprg_res_if;
	logic valid;
	logic ready;
	logic step_level;
	logic busy_res;
	logic done_res;

	modport source (output valid, output step_level, output busy_res, output done_res,
		input ready);
	modport sink   (input valid, input step_level, input busy_res, input done_res,
		output ready);
endinterface

interface sprg_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sprg_pkg::CFG_IDX_W-1:0]   index;
	logic [sprg_pkg::HP_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/stepper_pulse_ramp_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_pulse_ramp_generator
// Trapezoidal step pulse generator: accelerate, cruise, decelerate.
// ----------------------------------------------------------------------------
// Each command item (a one-microsecond tick or a move start) returns exactly
// one result item with the step pin level, busy and done. The block handles
// one item at a time. A tick goes straight to its result, or first through
// ST_PER when a new pulse needs its half-period worked out, ST_ENTER when the
// move ends, and ST_ENTER then ST_PER when a new phase begins. A move start
// from idle runs ST_DIV, ST_ENTER and ST_PER; ST_DIV is the one-bit-per-cycle
// restoring divider over QW = max(COUNT_WIDTH, 16) bits that forms the ramp
// increment span/slow; count/5 is a reciprocal multiply. A move of fewer than
// five steps skips the divide, and a move offered while busy goes straight to
// its result. Each result waits in its register until taken.
// Register writes are accepted at any time.
// ----------------------------------------------------------------------------
module stepper_pulse_ramp_generator #(
	parameter int COUNT_WIDTH = sprg_pkg::COUNT_W_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	sprg_cmd_if.sink        cmd,
	sprg_res_if.source      res,
	sprg_cfg_if.sink        cfg
);

	localparam int CW   = COUNT_WIDTH;
	localparam int QW   = (CW > sprg_pkg::HP_W) ? CW : sprg_pkg::HP_W;
	localparam int IT_W = $clog2(QW);
	localparam int HW   = sprg_pkg::HP_W;

	// count/5 as count * ceil(2^(CW+2)/5) >> (CW+2), exact for every CW-bit count
	localparam int            MUL_SH = CW + 2;
	localparam logic [CW-1:0] RECIP5 = CW'(((64'd1 << MUL_SH) +
		64'(sprg_pkg::RAMP_DIV - 1)) / 64'(sprg_pkg::RAMP_DIV));

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_ENTER = 5'b00100,
		ST_PER   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t               state_q;
	sprg_pkg::phase_t     phase_q;
	sprg_pkg::phase_t     ent_from_q;
	logic [HW-1:0]        min_q, max_q;
	logic [CW-1:0]        cnt_q, idx_q, slow_q, cruise_q;
	logic [HW-1:0]        inc_q, off_q, hp_q, tick_q;
	logic                 pin_q, done_q;
	logic [QW-1:0]        rem_q, quo_q, dvs_q;
	logic [IT_W-1:0]      it_q;

	// ---------------- config registers ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= sprg_pkg::MIN_HP_RESET;
			max_q <= sprg_pkg::MAX_HP_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				sprg_pkg::REG_MIN_HP: min_q <= cfg.data;
				sprg_pkg::REG_MAX_HP: max_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------- slow pulse count ----------------
	logic [CW-1:0]   cnt_c, slow_c;
	logic [2*CW-1:0] prod_c;

	assign cnt_c  = CW'(cmd.step_count);
	assign prod_c = {{CW{1'b0}}, cnt_c} * {{CW{1'b0}}, RECIP5};
	assign slow_c = CW'(prod_c[2*CW-1:MUL_SH]);

	// ---------------- divider step ----------------
	logic [QW:0]   trial_c;
	logic [QW-1:0] rem_nx, quo_nx;

	always_comb begin
		trial_c = {rem_q, quo_q[QW-1]} - {1'b0, dvs_q};
		if (!trial_c[QW]) begin
			rem_nx = trial_c[QW-1:0];
			quo_nx = {quo_q[QW-2:0], 1'b1};
		end else begin
			rem_nx = {rem_q[QW-2:0], quo_q[QW-1]};
			quo_nx = {quo_q[QW-2:0], 1'b0};
		end
	end

	// ---------------- half-period of the current pulse ----------------
	logic [HW-1:0]        span_c, offe_c, hp_c;
	logic [HW:0]          offm_c;
	logic signed [HW+1:0] hp_raw;

	always_comb begin
		span_c = (max_q < min_q) ? '0 : max_q - min_q;
		offm_c = {1'b0, off_q} + (HW+1)'(sprg_pkg::SNAP_MARGIN);
		offe_c = off_q;
		case (phase_q)
			sprg_pkg::PH_ACCEL: begin
				if (offm_c >= {1'b0, span_c})
					offe_c = span_c;
				hp_raw = $signed({2'b00, max_q}) - $signed({2'b00, offe_c});
			end
			sprg_pkg::PH_DECEL: begin
				if (offm_c > {1'b0, span_c})
					offe_c = span_c;
				hp_raw = $signed({2'b00, min_q}) + $signed({2'b00, offe_c});
			end
			default: hp_raw = $signed({2'b00, min_q});
		endcase
		if (hp_raw < $signed({2'b00, min_q}))
			hp_c = min_q;
		else if (hp_raw > $signed({2'b00, {HW{1'b1}}}))
			hp_c = {HW{1'b1}};
		else
			hp_c = hp_raw[HW-1:0];
		if (hp_c == '0)
			hp_c = HW'(1);
	end

	// ---------------- phase entry decision ----------------
	logic [CW+1:0]    used_c;
	logic [CW-1:0]    cruise_c, cruise_v, len_c;
	sprg_pkg::phase_t target_c;

	always_comb begin
		used_c   = {1'b0, slow_q, 1'b0} + (CW+2)'(1);
		cruise_c = ({2'b00, cnt_q} > used_c) ? CW'({2'b00, cnt_q} - used_c) : '0;
		cruise_v = (ent_from_q == sprg_pkg::PH_IDLE) ? cruise_c : cruise_q;
		case (ent_from_q)
			sprg_pkg::PH_IDLE:
				target_c = (slow_q != '0) ? sprg_pkg::PH_ACCEL :
				           (cruise_v != '0) ? sprg_pkg::PH_CRUISE : sprg_pkg::PH_IDLE;
			sprg_pkg::PH_ACCEL:
				target_c = (cruise_v != '0) ? sprg_pkg::PH_CRUISE :
				           (slow_q != '0) ? sprg_pkg::PH_DECEL : sprg_pkg::PH_IDLE;
			sprg_pkg::PH_CRUISE:
				target_c = (slow_q != '0) ? sprg_pkg::PH_DECEL : sprg_pkg::PH_IDLE;
			default: target_c = sprg_pkg::PH_IDLE;
		endcase
		len_c = (phase_q == sprg_pkg::PH_CRUISE) ? cruise_q : slow_q;
	end

	// ---------------- sequencer ----------------
	logic [HW-1:0] tick_nx;
	logic [CW-1:0] idx_nx;

	assign tick_nx = tick_q + HW'(1);
	assign idx_nx  = idx_q + CW'(1);

	assign cmd.ready      = (state_q == ST_IDLE);
	assign res.valid      = (state_q == ST_OUT);
	assign res.step_level = pin_q;
	assign res.busy_res   = (phase_q != sprg_pkg::PH_IDLE);
	assign res.done_res   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= sprg_pkg::PH_IDLE;
			ent_from_q <= sprg_pkg::PH_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			slow_q   <= '0;
			cruise_q <= '0;
			inc_q    <= '0;
			hp_q     <= '0;
			tick_q   <= '0;
			off_q    <= '0;
			pin_q    <= 1'b0;
			done_q   <= 1'b0;
			rem_q    <= '0;
			quo_q    <= '0;
			dvs_q    <= '0;
			it_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						done_q <= 1'b0;
						if (cmd.op == sprg_pkg::OP_MOVE) begin
							if (phase_q == sprg_pkg::PH_IDLE) begin
								cnt_q  <= cnt_c;
								slow_q <= slow_c;
								if (slow_c == '0) begin
									inc_q      <= '0;
									ent_from_q <= sprg_pkg::PH_IDLE;
									state_q    <= ST_ENTER;
								end else begin
									// increment = span / slow
									rem_q   <= '0;
									quo_q   <= QW'(span_c);
									dvs_q   <= QW'(slow_c);
									it_q    <= IT_W'(QW-1);
									state_q <= ST_DIV;
								end
							end else begin
								state_q <= ST_OUT;
							end
						end else if (phase_q != sprg_pkg::PH_IDLE) begin
							if (tick_nx >= hp_q) begin
								tick_q <= '0;
								if (pin_q) begin
									pin_q   <= 1'b0;
									state_q <= ST_OUT;
								end else begin
									idx_q <= idx_nx;
									off_q <= off_q + inc_q;
									if (idx_nx < len_c) begin
										pin_q   <= 1'b1;
										state_q <= ST_PER;
									end else begin
										ent_from_q <= phase_q;
										state_q    <= ST_ENTER;
									end
								end
							end else begin
								tick_q  <= tick_nx;
								state_q <= ST_OUT;
							end
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					if (it_q != '0) begin
						rem_q <= rem_nx;
						quo_q <= quo_nx;
						it_q  <= it_q - IT_W'(1);
					end else begin
						inc_q      <= quo_nx[HW-1:0];
						ent_from_q <= sprg_pkg::PH_IDLE;
						state_q    <= ST_ENTER;
					end
				end
				ST_ENTER: begin
					cruise_q <= cruise_v;
					phase_q  <= target_c;
					idx_q    <= '0;
					off_q    <= '0;
					tick_q   <= '0;
					if (target_c != sprg_pkg::PH_IDLE) begin
						pin_q   <= 1'b1;
						state_q <= ST_PER;
					end else begin
						pin_q   <= 1'b0;
						// a move that never starts gives no done
						done_q  <= (ent_from_q != sprg_pkg::PH_IDLE);
						state_q <= ST_OUT;
					end
				end
				ST_PER: begin
					hp_q    <= hp_c;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !cmd.ready)
		else $error("command taken while a result is pending");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.done_res) |-> !res.busy_res)
		else $error("done reported while still busy");

	a_idle_pin_low: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.busy_res) |-> !res.step_level)
		else $error("step pin high with no move running");

	a_hp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.busy_res) |-> (hp_q != '0))
		else $error("zero half-period during a move");
`endif

endmodule

`default_nettype wire
